// ===== hdl/rin_pkg.sv =====
// Shared types, register map and defaults for the nearest-neighbor image rotator.
package rin_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MaxSrcDimDefault = 256;
  localparam int MaxDstDimDefault = 512;
  localparam int PixelBitsDefault = 32;
  localparam int FracBitsDefault  = 14;

  // Fixed field widths
  localparam int CoordW  = 9;
  localparam int PixelW  = 32;
  localparam int TrigW   = 16;
  localparam int SrcDimW = 9;
  localparam int DstDimW = 10;

  // Configuration port
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_COSINE      = 3'd0,
    REG_SINE        = 3'd1,
    REG_SRC_WIDTH   = 3'd2,
    REG_SRC_HEIGHT  = 3'd3,
    REG_DST_WIDTH   = 3'd4,
    REG_DST_HEIGHT  = 3'd5
  } rin_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FETCH = 1'b1
  } rin_op_t;

  // Register reset values
  localparam logic signed [TrigW-1:0] SineReset      = '0;
  localparam logic [SrcDimW-1:0]      SrcWidthReset  = 9'd256;
  localparam logic [SrcDimW-1:0]      SrcHeightReset = 9'd256;
  localparam logic [DstDimW-1:0]      DstWidthReset  = 10'd256;
  localparam logic [DstDimW-1:0]      DstHeightReset = 10'd256;

  typedef struct packed {
    logic [0:0]        operation;
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
    logic [PixelW-1:0] pixel_value;
  } rin_in_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic [0:0]        inside_res;
  } rin_out_t;

endpackage

// ===== hdl/rin_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module rin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rotate_image_nearest.sv =====
// Top level of the nearest-neighbor image rotator: register bank, mapping pipeline, frame store.
//
// Usage:
//   Input items arrive on item and transfer at a clock edge where start is high
//   and busy is low. busy stays low: one item transfers in every cycle.
//   A write item (operation 0) stores pixel_value at (x_coord, y_coord) in the
//   frame store; columns or rows beyond the store are dropped. It gives no result.
//   A fetch item (operation 1) names a destination pixel. The block subtracts the
//   destination center, rotates by the programmed cosine and sine (Q2.FRAC_BITS),
//   rounds up, adds the source center and reads the frame store.
//   Each fetch gives one result on result, marked by done for one cycle; the
//   receiver takes it at the edge that ends that cycle and cannot stall it.
//   Throughput: one item per cycle, set by the single frame-store read port and
//   the multiplier stage, each used once per item.
//   Load the whole source image before fetching; never-written pixels read as junk.
//   Program the APB registers only while no fetch is in flight.
//   Reset (rst, synchronous) empties the pipeline and restores the registers to
//   an unrotated 256 x 256 setup; the frame store keeps its contents.
module rotate_image_nearest #(
  parameter int MAX_SRC_DIM = rin_pkg::MaxSrcDimDefault,
  parameter int MAX_DST_DIM = rin_pkg::MaxDstDimDefault,
  parameter int PIXEL_BITS  = rin_pkg::PixelBitsDefault,
  parameter int FRAC_BITS   = rin_pkg::FracBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  rin_pkg::rin_in_t                item,
  // result channel
  output logic                            done,
  output rin_pkg::rin_out_t               result,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rin_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rin_pkg::CfgDataW-1:0]    pwdata,
  output logic [rin_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);

  import rin_pkg::*;

  localparam int Depth  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int AddrW  = $clog2(Depth);
  localparam int OffW   = CoordW + 2;           // signed offset from the center
  localparam int ProdW  = TrigW + OffW;         // one product
  localparam int SumW   = ProdW + 2;            // sum of two products plus rounding
  localparam logic [SumW-1:0] RoundUp = SumW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [TrigW-1:0] CosineReset = TrigW'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [TrigW-1:0] cosine_value;
  logic signed [TrigW-1:0] sine_value;
  logic [SrcDimW-1:0]      source_width;
  logic [SrcDimW-1:0]      source_height;
  logic [DstDimW-1:0]      dest_width;
  logic [DstDimW-1:0]      dest_height;

  logic     cfg_write;
  rin_reg_t cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = rin_reg_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cosine_value  <= CosineReset;
      sine_value    <= SineReset;
      source_width  <= SrcWidthReset;
      source_height <= SrcHeightReset;
      dest_width    <= DstWidthReset;
      dest_height   <= DstHeightReset;
    end else if (cfg_write) begin
      case (cfg_reg)
        REG_COSINE:     cosine_value  <= pwdata[TrigW-1:0];
        REG_SINE:       sine_value    <= pwdata[TrigW-1:0];
        REG_SRC_WIDTH:  source_width  <= pwdata[SrcDimW-1:0];
        REG_SRC_HEIGHT: source_height <= pwdata[SrcDimW-1:0];
        REG_DST_WIDTH:  dest_width    <= pwdata[DstDimW-1:0];
        REG_DST_HEIGHT: dest_height   <= pwdata[DstDimW-1:0];
        default: ;  // unmapped addresses: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_COSINE:     prdata = CfgDataW'(cosine_value);
      REG_SINE:       prdata = CfgDataW'(sine_value);
      REG_SRC_WIDTH:  prdata = CfgDataW'(source_width);
      REG_SRC_HEIGHT: prdata = CfgDataW'(source_height);
      REG_DST_WIDTH:  prdata = CfgDataW'(dest_width);
      REG_DST_HEIGHT: prdata = CfgDataW'(dest_height);
      default:        prdata = '0;
    endcase
  end

  // Clamp sizes to what the store and the destination range allow
  logic [SrcDimW-1:0] src_w;
  logic [SrcDimW-1:0] src_h;
  logic [DstDimW-1:0] dst_w;
  logic [DstDimW-1:0] dst_h;

  assign src_w = (32'(source_width)  > MAX_SRC_DIM) ? SrcDimW'(MAX_SRC_DIM) : source_width;
  assign src_h = (32'(source_height) > MAX_SRC_DIM) ? SrcDimW'(MAX_SRC_DIM) : source_height;
  assign dst_w = (32'(dest_width)    > MAX_DST_DIM) ? DstDimW'(MAX_DST_DIM) : dest_width;
  assign dst_h = (32'(dest_height)   > MAX_DST_DIM) ? DstDimW'(MAX_DST_DIM) : dest_height;

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  assign busy = 1'b0;

  logic    s0_valid;
  rin_in_t s0_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_item <= item;
    end
  end

  // Offsets from the destination center, then the four products
  logic signed [OffW-1:0]  off_x;
  logic signed [OffW-1:0]  off_y;
  logic signed [ProdW-1:0] prod_cx_next;
  logic signed [ProdW-1:0] prod_sy_next;
  logic signed [ProdW-1:0] prod_sx_next;
  logic signed [ProdW-1:0] prod_cy_next;
  logic                    s0_fetch;
  logic                    s0_store;
  logic [AddrW-1:0]        waddr_next;

  assign off_x = $signed(OffW'(s0_item.x_coord)) - $signed(OffW'(dst_w >> 1));
  assign off_y = $signed(OffW'(s0_item.y_coord)) - $signed(OffW'(dst_h >> 1));

  assign prod_cx_next = cosine_value * off_x;
  assign prod_sy_next = sine_value   * off_y;
  assign prod_sx_next = sine_value   * off_x;
  assign prod_cy_next = cosine_value * off_y;

  assign s0_fetch = s0_valid && (rin_op_t'(s0_item.operation) == OP_FETCH);
  // Keep writes that land in the store, even beyond the programmed source size
  assign s0_store = s0_valid && (rin_op_t'(s0_item.operation) == OP_WRITE)
                    && (32'(s0_item.x_coord) < MAX_SRC_DIM)
                    && (32'(s0_item.y_coord) < MAX_SRC_DIM);
  assign waddr_next = AddrW'(s0_item.y_coord) * AddrW'(MAX_SRC_DIM)
                      + AddrW'(s0_item.x_coord);

  // ---------------------------------------------------------------------------
  // Stage 1: products registered; write port and read address driven from here
  // ---------------------------------------------------------------------------
  logic                    s1_fetch;
  logic                    s1_store;
  logic [AddrW-1:0]        s1_waddr;
  logic [PIXEL_BITS-1:0]   s1_wdata;
  logic signed [ProdW-1:0] s1_prod_cx;
  logic signed [ProdW-1:0] s1_prod_sy;
  logic signed [ProdW-1:0] s1_prod_sx;
  logic signed [ProdW-1:0] s1_prod_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_fetch <= 1'b0;
      s1_store <= 1'b0;
    end else begin
      s1_fetch <= s0_fetch;
      s1_store <= s0_store;
    end
  end

  always_ff @(posedge clk) begin
    s1_waddr   <= waddr_next;
    s1_wdata   <= s0_item.pixel_value[PIXEL_BITS-1:0];
    s1_prod_cx <= prod_cx_next;
    s1_prod_sy <= prod_sy_next;
    s1_prod_sx <= prod_sx_next;
    s1_prod_cy <= prod_cy_next;
  end

  // Rotate, round up and move to the source center
  logic [SumW-1:0]  rot_u;
  logic [SumW-1:0]  rot_v;
  logic [SumW-1:0]  src_x;
  logic [SumW-1:0]  src_y;
  logic             inside_next;
  logic [AddrW-1:0] raddr;

  assign rot_u = SumW'(s1_prod_cx) + SumW'(s1_prod_sy) + RoundUp;
  assign rot_v = SumW'(s1_prod_cy) - SumW'(s1_prod_sx) + RoundUp;
  assign src_x = SumW'($signed(rot_u) >>> FRAC_BITS) + SumW'(src_w >> 1);
  assign src_y = SumW'($signed(rot_v) >>> FRAC_BITS) + SumW'(src_h >> 1);

  // Sign bit clear rules out negative coordinates; a zero width or height makes its compare fail
  assign inside_next = !src_x[SumW-1] && (src_x < SumW'(src_w))
                       && !src_y[SumW-1] && (src_y < SumW'(src_h));
  assign raddr = AddrW'(src_y) * AddrW'(MAX_SRC_DIM) + AddrW'(src_x);

  // ---------------------------------------------------------------------------
  // Frame store: write and read of one cycle are both driven by the item in stage 1;
  // items reach it in order, so a fetch sees every earlier write.
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] rd_pixel;

  rin_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (Depth)
  ) u_frame_store (
    .clk   (clk),
    .we    (s1_store),
    .waddr (s1_waddr),
    .wdata (s1_wdata),
    .raddr (raddr),
    .rdata (rd_pixel)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: result register alongside the registered store data
  // ---------------------------------------------------------------------------
  logic s2_fetch;
  logic s2_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_fetch <= 1'b0;
    end else begin
      s2_fetch <= s1_fetch;
    end
  end

  always_ff @(posedge clk) begin
    s2_inside <= inside_next;
  end

  // Zero the pixel for points that fall outside the source
  assign done              = s2_fetch;
  assign result.pixel_out  = s2_inside ? PixelW'(rd_pixel) : '0;
  assign result.inside_res = s2_inside;

endmodule

// ===== verif/rotate_image_nearest_test.sv =====
// Self-checking testbench for rotate_image_nearest: pixel loads and rotated fetches, predicted and compared.
module rotate_image_nearest_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rin_pkg::*;

  localparam int SrcDim      = MaxSrcDimDefault;
  localparam int DstDim      = MaxDstDimDefault;
  localparam int FracQ       = FracBitsDefault;
  localparam int CoordMax    = (1 << CoordW) - 1;
  localparam int StallLimit  = 2000;
  localparam int ReportLimit = 10;
  localparam int PhaseCount  = 14;
  localparam int PhaseItems  = 48;
  localparam int PreloadMax  = 64;
  localparam int SettleGap   = 6;
  // Register index with nothing behind it; writes there must change nothing.
  localparam logic [2:0] UNMAPPED_REG = 3'd6;

  // One fetch still owed by the block, with its destination point for the report.
  typedef struct {
    rin_out_t          pix;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } awaited_t;

  // Predicts every fetch from its own copy of the registers and the frame store,
  // and matches the block's results against the oldest fetch still owed.
  class rotated_pixel_tracker;
    logic [TrigW-1:0]   cos_raw   = TrigW'(1 << FracQ);
    logic [TrigW-1:0]   sin_raw   = SineReset;
    logic [SrcDimW-1:0] src_w_raw = SrcWidthReset;
    logic [SrcDimW-1:0] src_h_raw = SrcHeightReset;
    logic [DstDimW-1:0] dst_w_raw = DstWidthReset;
    logic [DstDimW-1:0] dst_h_raw = DstHeightReset;
    logic [PixelW-1:0]  pixels [int];
    awaited_t           awaited [$];
    int unsigned        faults;

    function void flag(string msg);
      faults++;
      if (faults <= ReportLimit) $display("MISMATCH %0d at %0t: %s", faults, $realtime, msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COSINE:     cos_raw   = data[TrigW-1:0];
        REG_SINE:       sin_raw   = data[TrigW-1:0];
        REG_SRC_WIDTH:  src_w_raw = data[SrcDimW-1:0];
        REG_SRC_HEIGHT: src_h_raw = data[SrcDimW-1:0];
        REG_DST_WIDTH:  dst_w_raw = data[DstDimW-1:0];
        REG_DST_HEIGHT: dst_h_raw = data[DstDimW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CfgDataW-1:0] reg_image(rin_reg_t r, output logic [CfgDataW-1:0] mask);
      case (r)
        REG_COSINE:     begin mask = (1 << TrigW) - 1;   return CfgDataW'(cos_raw);   end
        REG_SINE:       begin mask = (1 << TrigW) - 1;   return CfgDataW'(sin_raw);   end
        REG_SRC_WIDTH:  begin mask = (1 << SrcDimW) - 1; return CfgDataW'(src_w_raw); end
        REG_SRC_HEIGHT: begin mask = (1 << SrcDimW) - 1; return CfgDataW'(src_h_raw); end
        REG_DST_WIDTH:  begin mask = (1 << DstDimW) - 1; return CfgDataW'(dst_w_raw); end
        default:        begin mask = (1 << DstDimW) - 1; return CfgDataW'(dst_h_raw); end
      endcase
    endfunction

    // Sizes as the mapping uses them: oversized values clamp to the store or the
    // largest destination.
    function int src_cols();
      return (src_w_raw > SrcDim) ? SrcDim : int'(src_w_raw);
    endfunction
    function int src_rows();
      return (src_h_raw > SrcDim) ? SrcDim : int'(src_h_raw);
    endfunction
    function int dst_cols();
      return (dst_w_raw > DstDim) ? DstDim : int'(dst_w_raw);
    endfunction
    function int dst_rows();
      return (dst_h_raw > DstDim) ? DstDim : int'(dst_h_raw);
    endfunction

    // Round a Q.FracQ product up to an integer; negative values shift as magnitudes.
    function longint ceil_q(longint v);
      if (v >= 0) return (v + (longint'(1) << FracQ) - 1) >>> FracQ;
      return -((-v) >>> FracQ);
    endfunction

    // Inverse-rotate a destination point into the source; 1 when it lands inside.
    function bit map_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           output int bx, output int by);
      longint c, s, ox, oy, u, v;
      int xi, yi;
      xi = x;
      yi = y;
      c  = longint'(shortint'(cos_raw));
      s  = longint'(shortint'(sin_raw));
      ox = xi - dst_cols() / 2;
      oy = yi - dst_rows() / 2;
      u  = c * ox + s * oy;
      v  = c * oy - s * ox;
      bx = int'(ceil_q(u)) + src_cols() / 2;
      by = int'(ceil_q(v)) + src_rows() / 2;
      return bx >= 0 && bx < src_cols() && by >= 0 && by < src_rows();
    endfunction

    function void log_transfer(rin_in_t it);
      awaited_t a;
      int bx, by;
      if (it.operation == OP_WRITE) begin
        if (it.x_coord < SrcDim && it.y_coord < SrcDim)
          pixels[int'(it.y_coord) * SrcDim + int'(it.x_coord)] = it.pixel_value;
        return;
      end
      a.x = it.x_coord;
      a.y = it.y_coord;
      a.pix.inside_res = map_point(it.x_coord, it.y_coord, bx, by);
      a.pix.pixel_out  = a.pix.inside_res ? pixels[by * SrcDim + bx] : '0;
      awaited.push_back(a);
    endfunction

    function void match_result(rin_out_t got);
      awaited_t a;
      if (awaited.size() == 0) begin
        flag($sformatf("result with no fetch owed: pixel %h inside %0b",
                       got.pixel_out, got.inside_res));
        return;
      end
      a = awaited.pop_front();
      if (got.pixel_out !== a.pix.pixel_out || got.inside_res !== a.pix.inside_res)
        flag($sformatf("fetch (%0d,%0d): expected pixel %h inside %0b, got pixel %h inside %0b",
                       a.x, a.y, a.pix.pixel_out, a.pix.inside_res,
                       got.pixel_out, got.inside_res));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic                busy;
  rin_in_t             item    = '0;
  logic                done;
  rin_out_t            result;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  rotated_pixel_tracker ledger = new();

  // Store entries the stimulus has already written; fetches never land on others.
  bit loaded [SrcDim * SrcDim];
  bit paced = 1'b0;
  int burst_left = 0;
  int idle_cycles = 0;

  rotate_image_nearest dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels at the edge: an item transfers when start is high and busy
  // low, a result transfers in the cycle done is high. Values seen here are the
  // ones from before the edge, since the stimulus only changes on nonblocking updates.
  always @(posedge clk) begin
    if (!rst && start && !busy) ledger.log_transfer(item);
    if (!rst && done) ledger.match_result(result);
  end

  // Watchdog: end the run when nothing transfers on any port for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic rin_in_t make_item(rin_op_t op, int x, int y, logic [PixelW-1:0] p);
    rin_in_t it;
    it.operation   = op;
    it.x_coord     = CoordW'(x);
    it.y_coord     = CoordW'(y);
    it.pixel_value = p;
    return it;
  endfunction

  // Present one item and hold it until it transfers. When pacing, open a random
  // gap between bursts; long bursts give stretches with no idling at all.
  task automatic send(rin_in_t it);
    if (paced) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(0, 1) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (it.operation == OP_WRITE && it.x_coord < SrcDim && it.y_coord < SrcDim)
      loaded[int'(it.y_coord) * SrcDim + int'(it.x_coord)] = 1'b1;
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Send a fetch; if it lands on a store entry not yet written, write that entry
  // first so the block never reads undefined contents.
  task automatic fetch_pixel(rin_in_t it);
    int bx, by;
    if (ledger.map_point(it.x_coord, it.y_coord, bx, by) && !loaded[by * SrcDim + bx])
      send(make_item(OP_WRITE, bx, by, $urandom()));
    send(it);
  endtask

  // Drop start and wait until every owed fetch has returned, then let the
  // pipeline run empty.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SettleGap) @(posedge clk);
  endtask

  // APB write: setup, then access until pready, then back to idle.
  task automatic reg_write(logic [2:0] idx, logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    ledger.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic reg_read(logic [2:0] idx, output logic [CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program all six registers, with junk above the field when asked, and read
  // each one back. Only called while no fetch is in flight.
  task automatic program_rotation(int cos_v, int sin_v, int sw, int sh, int dw, int dh,
                                  bit dirty);
    logic [CfgDataW-1:0] junk, rd, want, mask;
    rin_reg_t r;
    junk = dirty ? $urandom() : '0;
    reg_write(REG_COSINE,     {junk[CfgDataW-1:TrigW],   TrigW'(cos_v)});
    reg_write(REG_SINE,       {junk[CfgDataW-1:TrigW],   TrigW'(sin_v)});
    reg_write(REG_SRC_WIDTH,  {junk[CfgDataW-1:SrcDimW], SrcDimW'(sw)});
    reg_write(REG_SRC_HEIGHT, {junk[CfgDataW-1:SrcDimW], SrcDimW'(sh)});
    reg_write(REG_DST_WIDTH,  {junk[CfgDataW-1:DstDimW], DstDimW'(dw)});
    reg_write(REG_DST_HEIGHT, {junk[CfgDataW-1:DstDimW], DstDimW'(dh)});
    r = r.first();
    do begin
      reg_read(r, rd);
      want = ledger.reg_image(r, mask);
      if ((rd & mask) !== want)
        ledger.flag($sformatf("register %s read back %h, expected %h", r.name(), rd, want));
      r = r.next();
    end while (r != r.first());
  endtask

  // Directed items under the reset setup (identity, 256 x 256, center 128):
  // store corners and extreme words, writes beyond the store, fetches off the right
  // and bottom edges and beyond the destination, and a write followed at once by its fetch.
  task automatic directed_items();
    logic [PixelW-1:0] p;
    send(make_item(OP_WRITE, 0, 0, 32'h0000_0000));
    send(make_item(OP_WRITE, SrcDim - 1, SrcDim - 1, 32'hFFFF_FFFF));
    send(make_item(OP_WRITE, SrcDim - 1, 0, 32'hAAAA_AAAA));
    send(make_item(OP_WRITE, 0, SrcDim - 1, 32'h5555_5555));
    // beyond the store: dropped
    send(make_item(OP_WRITE, CoordMax, CoordMax, 32'hDEAD_BEEF));
    send(make_item(OP_WRITE, SrcDim, 7, 32'h0BAD_F00D));
    send(make_item(OP_WRITE, 7, SrcDim, 32'hF00D_0BAD));
    // the pixel word rides along on fetches and must be ignored
    fetch_pixel(make_item(OP_FETCH, 0, 0, 32'hFFFF_FFFF));
    fetch_pixel(make_item(OP_FETCH, SrcDim - 1, SrcDim - 1, 32'h0000_0000));
    fetch_pixel(make_item(OP_FETCH, SrcDim - 1, 0, $urandom()));
    fetch_pixel(make_item(OP_FETCH, 0, SrcDim - 1, $urandom()));
    // off the source: right, bottom, both, and beyond the destination
    fetch_pixel(make_item(OP_FETCH, SrcDim, SrcDim / 2, $urandom()));
    fetch_pixel(make_item(OP_FETCH, SrcDim / 2, SrcDim, $urandom()));
    fetch_pixel(make_item(OP_FETCH, CoordMax, CoordMax, $urandom()));
    fetch_pixel(make_item(OP_FETCH, 0, CoordMax, $urandom()));
    // read right after write, then overwrite and read again
    p = $urandom();
    send(make_item(OP_WRITE, 5, 5, p));
    fetch_pixel(make_item(OP_FETCH, 5, 5, ~p));
    send(make_item(OP_WRITE, 5, 5, ~p));
    fetch_pixel(make_item(OP_FETCH, 5, 5, p));
    fetch_pixel(make_item(OP_FETCH, SrcDim / 2, SrcDim / 2, $urandom()));
  endtask

  // Write every source pixel in raster order, as a normal user would, if 1 to PreloadMax pixels.
  task automatic preload_source();
    int sw, sh;
    sw = ledger.src_cols();
    sh = ledger.src_rows();
    if (sw * sh == 0 || sw * sh > PreloadMax) return;
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++)
        send(make_item(OP_WRITE, x, y, $urandom()));
  endtask

  // One random item: mostly fetches near the destination, writes mostly inside
  // the source, some inside the store but past the source, some past the store.
  task automatic random_item();
    int sw, sh, hx, hy, roll, x, y;
    sw   = ledger.src_cols();
    sh   = ledger.src_rows();
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      roll = $urandom_range(0, 9);
      if (roll < 8 && sw > 0 && sh > 0) begin
        x = $urandom_range(0, sw - 1);
        y = $urandom_range(0, sh - 1);
      end else if (roll < 9) begin
        x = $urandom_range(0, SrcDim - 1);
        y = $urandom_range(0, SrcDim - 1);
      end else begin
        x = $urandom_range(0, CoordMax);
        y = $urandom_range(SrcDim, CoordMax);
        if ($urandom_range(0, 1)) begin
          x = y;
          y = $urandom_range(0, CoordMax);
        end
      end
      send(make_item(OP_WRITE, x, y, $urandom()));
    end else begin
      hx = (ledger.dst_cols() + 1 > CoordMax) ? CoordMax : ledger.dst_cols() + 1;
      hy = (ledger.dst_rows() + 1 > CoordMax) ? CoordMax : ledger.dst_rows() + 1;
      if ($urandom_range(0, 99) < 85) begin
        x = $urandom_range(0, hx);
        y = $urandom_range(0, hy);
      end else begin
        x = $urandom_range(0, CoordMax);
        y = $urandom_range(0, CoordMax);
      end
      fetch_pixel(make_item(OP_FETCH, x, y, $urandom()));
    end
  endtask

  initial begin
    int cv, sv, sw, sh, dw, dh, n;
    real ang, c, s;
    bit dirty;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    settle();

    // Phases: the extremes first, then rotations at random angles with small
    // sources and their bounding destinations, now and then raw register noise.
    paced = 1'b1;
    for (int phase = 1; phase < PhaseCount; phase++) begin
      dirty = $urandom_range(0, 1);
      case (phase)
        1: program_rotation(-16384, 0, 256, 256, 512, 512, dirty);
        2: program_rotation(0, 16384, 1, 1, 1, 1, dirty);
        3: begin
          // out-of-range trig, oversized source and destination, unmapped index
          program_rotation(-32768, 32767, 511, 300, 1023, 600, 1'b1);
          reg_write(UNMAPPED_REG, $urandom());
        end
        4: program_rotation(0, -16384, 0, 5, 7, 9, dirty);
        5: program_rotation(11585, 11585, 7, 0, 12, 12, dirty);
        // identity over the full store: pick up pixels written past earlier sources
        6: program_rotation(16384, 0, 256, 256, 256, 256, dirty);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            program_rotation($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 1023), $urandom_range(0, 1023), dirty);
          end else begin
            ang = -real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
            c   = $cos(ang);
            s   = $sin(ang);
            cv  = $rtoi($floor(c * real'(1 << FracQ) + 0.5));
            sv  = $rtoi($floor(s * real'(1 << FracQ) + 0.5));
            sw  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(1, 256);
            sh  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(1, 256);
            if (c < 0.0) c = -c;
            if (s < 0.0) s = -s;
            dw  = $rtoi($ceil(real'(sw) * c + real'(sh) * s));
            dh  = $rtoi($ceil(real'(sw) * s + real'(sh) * c));
            dw  = (dw < 1) ? 1 : ((dw > DstDim) ? DstDim : dw);
            dh  = (dh < 1) ? 1 : ((dh > DstDim) ? DstDim : dh);
            program_rotation(cv, sv, sw, sh, dw, dh, dirty);
          end
        end
      endcase

      preload_source();
      for (n = 0; n < PhaseItems; n++) begin
        random_item();
        // now and then hold the sender until the pipeline is empty
        if ($urandom_range(0, 99) == 0) settle();
      end
      settle();
    end

    if (ledger.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rin_pkg.sv
hdl/rin_ram.sv
hdl/rotate_image_nearest.sv
verif/rotate_image_nearest_test.sv
